FILE: src/mts_pkg.sv
// ---------------------------------------------------------------------------
// Mesh thermal sweep package
// Control word layout, microcode program, operation codes and register
// indexes shared by the thermal sweep sequencer.
// ---------------------------------------------------------------------------
package mts_pkg;

   localparam int STEP_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_AMBIENT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEATING  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLING  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRANSFER = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE     = 3'd4;

   localparam logic signed [15:0] AMBIENT_RESET  = 16'sd11520;
   localparam logic [14:0]        HEATING_RESET  = 15'd2560;
   localparam logic [15:0]        COOLING_RESET  = 16'd6554;
   localparam logic [15:0]        TRANSFER_RESET = 16'd3277;
   localparam logic [3:0]         SIDE_RESET     = 4'd8;

   localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] STEP_LOADT = 4'd1;
   localparam logic [STEP_W-1:0] STEP_GAP   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MCOOL = 4'd3;
   localparam logic [STEP_W-1:0] STEP_RW    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MW    = 4'd5;
   localparam logic [STEP_W-1:0] STEP_RN    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MN    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_RE    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_ME    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_RS    = 4'd10;
   localparam logic [STEP_W-1:0] STEP_MS    = 4'd11;
   localparam logic [STEP_W-1:0] STEP_FIN   = 4'd12;

   localparam logic [2:0] RD_NONE  = 3'd0;
   localparam logic [2:0] RD_OWN   = 3'd1;
   localparam logic [2:0] RD_WEST  = 3'd2;
   localparam logic [2:0] RD_NORTH = 3'd3;
   localparam logic [2:0] RD_EAST  = 3'd4;
   localparam logic [2:0] RD_SOUTH = 3'd5;

   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_HEAT = 2'd1;
   localparam logic [1:0] MUL_COOL = 2'd2;
   localparam logic [1:0] MUL_MIX  = 2'd3;

   localparam logic [2:0] JC_NONE        = 3'd0;
   localparam logic [2:0] JC_ALWAYS      = 3'd1;
   localparam logic [2:0] JC_NOT_PRESENT = 3'd2;
   localparam logic [2:0] JC_NO_WEST     = 3'd3;
   localparam logic [2:0] JC_NO_NORTH    = 3'd4;
   localparam logic [2:0] JC_NO_EAST     = 3'd5;
   localparam logic [2:0] JC_NO_SOUTH    = 3'd6;

   typedef struct packed {
      logic              hold_idle;
      logic              ld_t;
      logic [2:0]        rd_sel;
      logic [1:0]        mul_op;
      logic [2:0]        jmp_cond;
      logic [STEP_W-1:0] jmp_tgt;
      logic              fin;
   } ctrl_word_type;

   // A taken jump suppresses the read and the multiply of its step.
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = '0;
      case (step)
         STEP_IDLE: begin
            cw.hold_idle = 1'b1;
            cw.rd_sel    = RD_OWN;
         end
         STEP_LOADT: begin
            cw.ld_t     = 1'b1;
            cw.mul_op   = MUL_HEAT;
            cw.jmp_cond = JC_NOT_PRESENT;
            cw.jmp_tgt  = STEP_RW;
         end
         STEP_GAP: begin
            cw.mul_op = MUL_NONE;
         end
         STEP_MCOOL: begin
            cw.mul_op = MUL_COOL;
         end
         STEP_RW: begin
            cw.rd_sel   = RD_WEST;
            cw.jmp_cond = JC_NO_WEST;
            cw.jmp_tgt  = STEP_RN;
         end
         STEP_MW: begin
            cw.mul_op = MUL_MIX;
         end
         STEP_RN: begin
            cw.rd_sel   = RD_NORTH;
            cw.jmp_cond = JC_NO_NORTH;
            cw.jmp_tgt  = STEP_RE;
         end
         STEP_MN: begin
            cw.mul_op = MUL_MIX;
         end
         STEP_RE: begin
            cw.rd_sel   = RD_EAST;
            cw.jmp_cond = JC_NO_EAST;
            cw.jmp_tgt  = STEP_RS;
         end
         STEP_ME: begin
            cw.mul_op = MUL_MIX;
         end
         STEP_RS: begin
            cw.rd_sel   = RD_SOUTH;
            cw.jmp_cond = JC_NO_SOUTH;
            cw.jmp_tgt  = STEP_FIN;
         end
         STEP_MS: begin
            cw.mul_op = MUL_MIX;
         end
         STEP_FIN: begin
            cw.fin = 1'b1;
         end
         default: begin
            cw.jmp_cond = JC_ALWAYS;
            cw.jmp_tgt  = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

FILE: src/mesh_thermal_sweep.sv
// ---------------------------------------------------------------------------
// Mesh thermal sweep
// Keeps a square grid of Q8.8 tile temperatures and updates one tile per
// item in raster order: heating, cooling toward ambient and neighbor mixing.
// ---------------------------------------------------------------------------
// Usage: one req item per tile, in raster order, carrying the tile's activity
// and router flag. An item is taken when req_valid is high and req_stall is
// low; each item yields one rsp item with the new temperature, the tile
// coordinates and a mark on the last tile of the sweep, taken when rsp_valid
// is high and rsp_stall is low. Registers are written on the csr channel,
// which is always ready, and should be changed only while the block is idle.
// A microcoded sequencer runs one item at a time through a single multiplier
// and a temperature store with one read and one write port. The tile is read
// when the item is taken and loaded in the LOADT step, which also starts the
// heating when the router is present; cooling then follows in MCOOL. Each
// existing neighbor is read and mixed in, and a missing one is skipped. FIN
// writes the tile back and loads the result; a new item can be taken in the
// cycle after the result is loaded. After reset the store is filled with the
// ambient reset value, one entry per cycle for all MAX_SIDE*MAX_SIDE entries,
// while req_stall stays high. A stalled result holds in the output register;
// a new item can be taken meanwhile, but its result waits for that register.
// ---------------------------------------------------------------------------
module mesh_thermal_sweep #(
   parameter int MAX_SIDE   = 8,
   parameter int TEMP_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [8:0]                          req_activity,
   input  logic                                req_router_present,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [15:0]                  rsp_temperature,
   output logic [2:0]                          rsp_tile_x,
   output logic [2:0]                          rsp_tile_y,
   output logic                                rsp_sweep_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mts_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COORD_W = $clog2(MAX_SIDE);
   localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
   localparam int XW      = (COORD_W > 3) ? COORD_W : 3;
   localparam int EXT_W   = (TEMP_WIDTH > 16) ? TEMP_WIDTH : 16;
   localparam int DW      = EXT_W + 1;
   localparam int PW      = DW + 17;
   localparam int SUM_W   = DW + 2;
   localparam longint TEMP_MAX = (longint'(1) <<< (TEMP_WIDTH - 1)) - 1;
   localparam logic signed [TEMP_WIDTH-1:0] RESET_TEMP =
      (longint'(mts_pkg::AMBIENT_RESET) > TEMP_MAX) ?
      TEMP_WIDTH'(TEMP_MAX) : TEMP_WIDTH'(mts_pkg::AMBIENT_RESET);

   logic signed [15:0]  ambient_ff;
   logic [14:0]         heating_ff;
   logic [15:0]         cooling_ff;
   logic [15:0]         transfer_ff;
   logic [3:0]          side_ff;

   logic [mts_pkg::STEP_W-1:0] upc_ff, upc_in;
   logic                       clearing_ff;
   logic [ADDR_W-1:0]          clr_ff;
   logic [COORD_W-1:0]         col_ff, col_in, row_ff, row_in;
   logic [8:0]                 act_ff;
   logic                       present_ff;
   logic signed [TEMP_WIDTH-1:0] t_ff, t_in, t_next, rd_ff;
   logic signed [PW-1:0]       prod_ff, prod_in;
   logic [1:0]                 pend_ff, pend_in;
   logic                       rsp_valid_ff;
   logic signed [15:0]         rsp_temp_ff;
   logic [2:0]                 rsp_x_ff, rsp_y_ff;
   logic                       rsp_last_ff;

   logic signed [TEMP_WIDTH-1:0] store_mem [DEPTH];

   mts_pkg::ctrl_word_type cw;
   logic                   jump, rd_en, mul_fire, fin_fire, out_free;
   logic                   req_accept, rsp_accept;
   logic [SIDE_W-1:0]      side_use, col_p1, row_p1;
   logic [COORD_W-1:0]     cx, cy;
   logic [ADDR_W-1:0]      own_idle, own_busy, rd_addr, wr_addr;
   logic signed [TEMP_WIDTH-1:0] wr_data;
   logic                   wr_en;
   logic signed [16:0]     a_op;
   logic signed [DW-1:0]   b_op;
   logic signed [PW-1:0]   shifted;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-TEMP_WIDTH:0] top_bits;
   logic signed [EXT_W-1:0] t_ext;
   logic [XW-1:0]          x_ext, y_ext;

   assign cw         = mts_pkg::ucode_rom(upc_ff);
   assign req_stall  = clearing_ff || (upc_ff != mts_pkg::STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (side_ff == 4'd0) begin
         side_use = SIDE_W'(1);
      end else if (32'(side_ff) > MAX_SIDE) begin
         side_use = SIDE_W'(MAX_SIDE);
      end else begin
         side_use = SIDE_W'(side_ff);
      end
   end

   assign cx     = (SIDE_W'(col_ff) >= side_use) ? '0 : col_ff;
   assign cy     = (SIDE_W'(row_ff) >= side_use) ? '0 : row_ff;
   assign col_p1 = SIDE_W'(col_ff) + SIDE_W'(1);
   assign row_p1 = SIDE_W'(row_ff) + SIDE_W'(1);

   assign own_idle = ADDR_W'(cy) * ADDR_W'(MAX_SIDE) + ADDR_W'(cx);
   assign own_busy = ADDR_W'(row_ff) * ADDR_W'(MAX_SIDE) + ADDR_W'(col_ff);

   always_comb begin
      case (cw.jmp_cond)
         mts_pkg::JC_NONE:        jump = 1'b0;
         mts_pkg::JC_ALWAYS:      jump = 1'b1;
         mts_pkg::JC_NOT_PRESENT: jump = !present_ff;
         mts_pkg::JC_NO_WEST:     jump = (col_ff == '0);
         mts_pkg::JC_NO_NORTH:    jump = (row_ff == '0);
         mts_pkg::JC_NO_EAST:     jump = !(col_p1 < side_use);
         mts_pkg::JC_NO_SOUTH:    jump = !(row_p1 < side_use);
         default:                 jump = 1'b0;
      endcase
   end

   assign rd_en    = (cw.rd_sel != mts_pkg::RD_NONE) && !jump;
   assign mul_fire = (cw.mul_op != mts_pkg::MUL_NONE) && !jump;
   assign fin_fire = cw.fin && out_free;

   always_comb begin
      case (cw.rd_sel)
         mts_pkg::RD_OWN:   rd_addr = own_idle;
         mts_pkg::RD_WEST:  rd_addr = own_busy - ADDR_W'(1);
         mts_pkg::RD_NORTH: rd_addr = own_busy - ADDR_W'(MAX_SIDE);
         mts_pkg::RD_EAST:  rd_addr = own_busy + ADDR_W'(1);
         mts_pkg::RD_SOUTH: rd_addr = own_busy + ADDR_W'(MAX_SIDE);
         default:           rd_addr = own_busy;
      endcase
   end

   always_comb begin
      if (cw.hold_idle) begin
         upc_in = req_accept ? upc_ff + mts_pkg::STEP_W'(1) : upc_ff;
      end else if (cw.fin) begin
         upc_in = out_free ? mts_pkg::STEP_IDLE : upc_ff;
      end else if (jump) begin
         upc_in = cw.jmp_tgt;
      end else begin
         upc_in = upc_ff + mts_pkg::STEP_W'(1);
      end
   end

   always_comb begin
      case (cw.mul_op)
         mts_pkg::MUL_HEAT: begin
            a_op = $signed({2'b00, heating_ff});
            b_op = $signed(DW'(act_ff));
         end
         mts_pkg::MUL_COOL: begin
            a_op = $signed({1'b0, cooling_ff});
            b_op = DW'(t_ff) - DW'(ambient_ff);
         end
         mts_pkg::MUL_MIX: begin
            a_op = $signed({1'b0, transfer_ff});
            b_op = DW'(rd_ff) - DW'(t_ff);
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
      prod_in = a_op * b_op;
      pend_in = mul_fire ? cw.mul_op : mts_pkg::MUL_NONE;
   end

   // The arithmetic shift rounds each product toward minus infinity.
   always_comb begin
      shifted = (pend_ff == mts_pkg::MUL_HEAT) ? (prod_ff >>> 8) : (prod_ff >>> 16);
      if (pend_ff == mts_pkg::MUL_COOL) begin
         sum = SUM_W'(t_ff) - SUM_W'($signed(shifted[DW:0]));
      end else begin
         sum = SUM_W'(t_ff) + SUM_W'($signed(shifted[DW:0]));
      end
      top_bits = sum[SUM_W-1:TEMP_WIDTH-1];
      if (pend_ff == mts_pkg::MUL_NONE) begin
         t_next = t_ff;
      end else if ((&top_bits) || !(|top_bits)) begin
         t_next = sum[TEMP_WIDTH-1:0];
      end else if (sum[SUM_W-1]) begin
         t_next = $signed({1'b1, {(TEMP_WIDTH-1){1'b0}}});
      end else begin
         t_next = $signed({1'b0, {(TEMP_WIDTH-1){1'b1}}});
      end
      t_in = cw.ld_t ? rd_ff : t_next;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         col_in = cx;
         row_in = cy;
      end else if (fin_fire) begin
         if (col_p1 >= side_use) begin
            col_in = '0;
            row_in = (row_p1 >= side_use) ? '0 : COORD_W'(row_p1);
         end else begin
            col_in = COORD_W'(col_p1);
         end
      end
   end

   assign wr_en   = clearing_ff || fin_fire;
   assign wr_addr = clearing_ff ? clr_ff : own_busy;
   assign wr_data = clearing_ff ? RESET_TEMP : t_next;
   assign t_ext   = EXT_W'(t_next);
   assign x_ext   = XW'(col_ff);
   assign y_ext   = XW'(row_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ambient_ff   <= mts_pkg::AMBIENT_RESET;
         heating_ff   <= mts_pkg::HEATING_RESET;
         cooling_ff   <= mts_pkg::COOLING_RESET;
         transfer_ff  <= mts_pkg::TRANSFER_RESET;
         side_ff      <= mts_pkg::SIDE_RESET;
         upc_ff       <= mts_pkg::STEP_IDLE;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= mts_pkg::MUL_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mts_pkg::CSR_AMBIENT:  ambient_ff  <= $signed(csr_data);
               mts_pkg::CSR_HEATING:  heating_ff  <= csr_data[14:0];
               mts_pkg::CSR_COOLING:  cooling_ff  <= csr_data;
               mts_pkg::CSR_TRANSFER: transfer_ff <= csr_data;
               mts_pkg::CSR_SIDE:     side_ff     <= csr_data[3:0];
               default: begin
               end
            endcase
         end
         if (clearing_ff) begin
            clr_ff <= clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         upc_ff  <= upc_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         pend_ff <= pend_in;
         if (fin_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_accept) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff     <= req_activity;
         present_ff <= req_router_present;
      end
      if (mul_fire) begin
         prod_ff <= prod_in;
      end
      t_ff <= t_in;
      if (fin_fire) begin
         rsp_temp_ff <= t_ext[15:0];
         rsp_x_ff    <= x_ext[2:0];
         rsp_y_ff    <= y_ext[2:0];
         rsp_last_ff <= (col_p1 == side_use) && (row_p1 == side_use);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temp_ff;
   assign rsp_tile_x      = rsp_x_ff;
   assign rsp_tile_y      = rsp_y_ff;
   assign rsp_sweep_last  = rsp_last_ff;

`ifndef SYNTH
   // A product must be folded into the temperature before the next multiply.
   a_pend_before_mul: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != mts_pkg::MUL_NONE) |-> !mul_fire)
      else $error("multiply issued while an accumulate is pending");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_accept)
      else $error("item taken during the store clearing pass");

   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      (upc_ff != mts_pkg::STEP_IDLE) |->
      ((SIDE_W'(col_ff) < side_use) && (SIDE_W'(row_ff) < side_use)))
      else $error("tile position outside the grid in use");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(upc_ff) == mts_pkg::STEP_FIN))
      else $error("result raised outside the final step");
`endif

endmodule
